>>> hdl/thresholded_frame_centroid_core_defines.svh
// Assertion macros for the thresholded frame centroid core.
// Included by the checker; no other dependencies.
`ifndef THRESHOLDED_FRAME_CENTROID_CORE_DEFINES_SVH
`define THRESHOLDED_FRAME_CENTROID_CORE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define TFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define TFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tfc_pkg.sv
// Shared types, constants and the speed table of the frame centroid core.
// No dependencies; imported by every RTL module.
`timescale 1ns / 1ps

package tfc_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;

    localparam int PIX_W       = 8;
    localparam int SKIP_W      = 5;
    localparam int FW_W        = 10;
    localparam int PHASE_W     = 4;
    localparam int HIT_W       = 19;
    localparam int SPD_W       = 9;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int CNT_W       = COL_W + 1;
    localparam int RCNT_W      = ROW_W + 1;

    // Quotient width covers the widest mean; sums are sized so they never overflow.
    localparam int QW_A        = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int QUO_W       = (QW_A > PIX_W) ? QW_A : PIX_W;
    localparam int SUM_W       = QUO_W + HIT_W;
    localparam int STEP_W      = $clog2(QUO_W);

    localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

    localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd100;
    localparam logic [PIX_W-1:0] SPEED_LO      = 8'd150;
    localparam logic [PIX_W-1:0] SPEED_HI      = 8'd165;
    localparam logic [SKIP_W-1:0] SKIP_MAX     = 5'd16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Configuration port
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam logic [1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_SKIP        = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0]  threshold;
        logic [SKIP_W-1:0] skip;
        logic [FW_W-1:0]   frame_width;
    } tfc_cfg_t;

    // Totals of one finished frame, handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [SUM_W-1:0] sum_b;
        logic [HIT_W-1:0] hits;
    } tfc_frame_t;

    // 256 - (c * 179) / 15 for clamped brightness offset c
    function automatic logic [SPD_W-1:0] tfc_speed(input logic [3:0] c);
        logic [SPD_W-1:0] s;
        unique case (c)
            4'd0:  s = 9'd256;
            4'd1:  s = 9'd245;
            4'd2:  s = 9'd233;
            4'd3:  s = 9'd221;
            4'd4:  s = 9'd209;
            4'd5:  s = 9'd197;
            4'd6:  s = 9'd185;
            4'd7:  s = 9'd173;
            4'd8:  s = 9'd161;
            4'd9:  s = 9'd149;
            4'd10: s = 9'd137;
            4'd11: s = 9'd125;
            4'd12: s = 9'd113;
            4'd13: s = 9'd101;
            4'd14: s = 9'd89;
            4'd15: s = 9'd77;
        endcase
        return s;
    endfunction

endpackage

>>> hdl/tfc_queue.sv
// Short queue of frame totals between the pixel front and the divide back.
// Depends on tfc_pkg.
`timescale 1ns / 1ps

module tfc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tfc_pkg::tfc_frame_t push_data,
    input  logic               pop,
    output tfc_pkg::tfc_frame_t pop_data,
    output logic               full,
    output logic               empty
);
    import tfc_pkg::*;

    tfc_frame_t          entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/tfc_front.sv
// Pixel front: raster position, subsample phases, threshold test and sums.
// Depends on tfc_pkg; pushes frame totals into tfc_queue.
`timescale 1ns / 1ps

module tfc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  tfc_pkg::tfc_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          pixel,
    input  logic                last_pixel,
    input  logic                queue_full,
    output logic                push,
    output tfc_pkg::tfc_frame_t push_data
);
    import tfc_pkg::*;

    logic [COL_W-1:0]   column_reg, column_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PHASE_W-1:0] cphase_reg, cphase_next;
    logic [PHASE_W-1:0] rphase_reg, rphase_next;
    logic [SUM_W-1:0]   sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]   sum_y_reg, sum_y_next;
    logic [SUM_W-1:0]   sum_b_reg, sum_b_next;
    logic [HIT_W-1:0]   hits_reg, hits_next;

    logic               accept;
    logic               hit;
    logic [SKIP_W-1:0]  step;
    logic [CNT_W-1:0]   width;
    logic [SUM_W-1:0]   sx, sy, sb;
    logic [HIT_W-1:0]   hc;

    function automatic logic [PHASE_W-1:0] phase_adv(input logic [PHASE_W-1:0] p,
                                                     input logic [SKIP_W-1:0] s);
        logic [SKIP_W-1:0] p1;
        p1 = SKIP_W'(p) + 1'b1;
        return (p1 >= s) ? '0 : PHASE_W'(p1);
    endfunction

    // Stall only when the queue cannot take another frame record
    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (cfg.skip == '0)
            step = SKIP_W'(1);
        else if (cfg.skip > SKIP_MAX)
            step = SKIP_MAX;
        else
            step = cfg.skip;

        if (cfg.frame_width == '0)
            width = CNT_W'(1);
        else if (int'(cfg.frame_width) > MAX_WIDTH)
            width = CNT_W'(MAX_WIDTH);
        else
            width = CNT_W'(cfg.frame_width);
    end

    always_comb
    begin
        hit = (cphase_reg == '0) && (rphase_reg == '0) && (pixel > cfg.threshold)
              && (hits_reg != HIT_MAX);
        sx  = hit ? sum_x_reg + SUM_W'(column_reg) : sum_x_reg;
        sy  = hit ? sum_y_reg + SUM_W'(row_reg) : sum_y_reg;
        sb  = hit ? sum_b_reg + SUM_W'(pixel) : sum_b_reg;
        hc  = hit ? hits_reg + 1'b1 : hits_reg;

        push            = accept && last_pixel;
        push_data.sum_x = sx;
        push_data.sum_y = sy;
        push_data.sum_b = sb;
        push_data.hits  = hc;

        column_next = column_reg;
        row_next    = row_reg;
        cphase_next = cphase_reg;
        rphase_next = rphase_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_b_next  = sum_b_reg;
        hits_next   = hits_reg;

        if (accept)
        begin
            if (last_pixel)
            begin
                column_next = '0;
                row_next    = '0;
                cphase_next = '0;
                rphase_next = '0;
                sum_x_next  = '0;
                sum_y_next  = '0;
                sum_b_next  = '0;
                hits_next   = '0;
            end
            else
            begin
                sum_x_next = sx;
                sum_y_next = sy;
                sum_b_next = sb;
                hits_next  = hc;
                if ((CNT_W'(column_reg) + 1'b1) >= width)
                begin
                    column_next = '0;
                    cphase_next = '0;
                    if ((RCNT_W'(row_reg) + 1'b1) >= RCNT_W'(MAX_HEIGHT))
                        row_next = '0;
                    else
                        row_next = row_reg + 1'b1;
                    rphase_next = phase_adv(rphase_reg, step);
                end
                else
                begin
                    column_next = column_reg + 1'b1;
                    cphase_next = phase_adv(cphase_reg, step);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            cphase_reg <= '0;
            rphase_reg <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_b_reg  <= '0;
            hits_reg   <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            cphase_reg <= cphase_next;
            rphase_reg <= rphase_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            sum_b_reg  <= sum_b_next;
            hits_reg   <= hits_next;
        end
    end

endmodule

>>> hdl/tfc_back.sv
// Frame back: shared restoring divider for the three means, speed map, result register.
// Depends on tfc_pkg; pops frame records from tfc_queue.
`timescale 1ns / 1ps

module tfc_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     queue_empty,
    input  tfc_pkg::tfc_frame_t      queue_data,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [tfc_pkg::COL_W-1:0] mean_x,
    output logic [tfc_pkg::ROW_W-1:0] mean_y,
    output logic [7:0]               mean_brightness,
    output logic [8:0]               speed_q8,
    output logic                     found
);
    import tfc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_B = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        sel_reg, sel_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  dsh_reg, dsh_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    tfc_frame_t        rec_reg, rec_next;
    logic [COL_W-1:0]  mx_reg, mx_next;
    logic [ROW_W-1:0]  my_reg, my_next;
    logic [PIX_W-1:0]  mb_reg, mb_next;
    logic              hit_reg, hit_next;

    logic              out_valid_reg, out_valid_next;
    logic [COL_W-1:0]  out_mx_reg, out_mx_next;
    logic [ROW_W-1:0]  out_my_reg, out_my_next;
    logic [PIX_W-1:0]  out_mb_reg, out_mb_next;
    logic [SPD_W-1:0]  out_sp_reg, out_sp_next;
    logic              out_fd_reg, out_fd_next;

    logic              ge;
    logic [QUO_W-1:0]  quo_new;
    logic [3:0]        clamp_off;

    assign out_valid       = out_valid_reg;
    assign mean_x          = out_mx_reg;
    assign mean_y          = out_my_reg;
    assign mean_brightness = out_mb_reg;
    assign speed_q8        = out_sp_reg;
    assign found           = out_fd_reg;

    always_comb
    begin
        if (mb_reg < SPEED_LO)
            clamp_off = '0;
        else if (mb_reg > SPEED_HI)
            clamp_off = 4'(SPEED_HI - SPEED_LO);
        else
            clamp_off = 4'(mb_reg - SPEED_LO);
    end

    // One quotient bit per cycle
    assign ge      = (rem_reg >= dsh_reg);
    assign quo_new = {quo_reg[QUO_W-2:0], ge};

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quo_next   = quo_reg;
        rec_next   = rec_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        mb_next    = mb_reg;
        hit_next   = hit_reg;
        pop        = 1'b0;

        out_valid_next = out_valid_reg && out_stall;
        out_mx_next    = out_mx_reg;
        out_my_next    = out_my_reg;
        out_mb_next    = out_mb_reg;
        out_sp_next    = out_sp_reg;
        out_fd_next    = out_fd_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop      = 1'b1;
                    rec_next = queue_data;
                    if (queue_data.hits == '0)
                    begin
                        mx_next    = '0;
                        my_next    = '0;
                        mb_next    = '0;
                        hit_next   = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        hit_next   = 1'b1;
                        rem_next   = queue_data.sum_x;
                        dsh_next   = SUM_W'(queue_data.hits) << (QUO_W - 1);
                        quo_next   = '0;
                        step_next  = STEP_W'(QUO_W - 1);
                        sel_next   = SEL_X;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? rem_reg - dsh_reg : rem_reg;
                if (step_reg == '0)
                begin
                    quo_next  = '0;
                    step_next = STEP_W'(QUO_W - 1);
                    dsh_next  = SUM_W'(rec_reg.hits) << (QUO_W - 1);
                    unique case (sel_reg)
                        SEL_X:
                        begin
                            mx_next  = quo_new[COL_W-1:0];
                            rem_next = rec_reg.sum_y;
                            sel_next = SEL_Y;
                        end
                        SEL_Y:
                        begin
                            my_next  = quo_new[ROW_W-1:0];
                            rem_next = rec_reg.sum_b;
                            sel_next = SEL_B;
                        end
                        default:
                        begin
                            mb_next    = quo_new[PIX_W-1:0];
                            state_next = ST_FINISH;
                        end
                    endcase
                end
                else
                begin
                    quo_next  = quo_new;
                    dsh_next  = dsh_reg >> 1;
                    step_next = step_reg - 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_mx_next    = mx_reg;
                    out_my_next    = my_reg;
                    out_mb_next    = mb_reg;
                    out_sp_next    = hit_reg ? tfc_speed(clamp_off) : '0;
                    out_fd_next    = hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg    <= sel_next;
        step_reg   <= step_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quo_reg    <= quo_next;
        rec_reg    <= rec_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        mb_reg     <= mb_next;
        hit_reg    <= hit_next;
        out_mx_reg <= out_mx_next;
        out_my_reg <= out_my_next;
        out_mb_reg <= out_mb_next;
        out_sp_reg <= out_sp_next;
        out_fd_reg <= out_fd_next;
    end

endmodule

>>> hdl/thresholded_frame_centroid_core.sv
// Thresholded frame centroid core. Takes one depth pixel beat per clock in raster
// order and stalls the pixel input only while two finished frames are still
// waiting for the divider. At the beat marked last_pixel it hands the frame
// totals to the back end, which produces one result beat from the shared
// bit-serial divider, working out one quotient bit a cycle for each of mean x,
// mean y and mean brightness. Configuration writes take effect on the next pixel.
// No clearing pass after reset.
// Depends on tfc_pkg, tfc_front, tfc_queue and tfc_back.
`timescale 1ns / 1ps

module thresholded_frame_centroid_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tfc_pkg::ADDR_W-1:0]  paddr,
    input  logic [tfc_pkg::DATA_W-1:0]  pwdata,
    output logic [tfc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // pixel channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  pixel,
    input  logic                        last_pixel,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tfc_pkg::COL_W-1:0]   mean_x,
    output logic [tfc_pkg::ROW_W-1:0]   mean_y,
    output logic [7:0]                  mean_brightness,
    output logic [8:0]                  speed_q8,
    output logic                        found
);
    import tfc_pkg::*;

    logic [PIX_W-1:0]  threshold_reg, threshold_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic [FW_W-1:0]   frame_width_reg, frame_width_next;

    tfc_cfg_t   cfg;
    tfc_frame_t push_data;
    tfc_frame_t pop_data;
    logic       push, pop, q_full, q_empty;
    logic       wr_en;
    logic [1:0] reg_idx;

    // ---- register file: word addressed, writes complete in the access phase
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        threshold_next   = threshold_reg;
        skip_next        = skip_reg;
        frame_width_next = frame_width_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_THRESHOLD:   threshold_next   = pwdata[PIX_W-1:0];
                REG_SKIP:        skip_next        = pwdata[SKIP_W-1:0];
                REG_FRAME_WIDTH: frame_width_next = pwdata[FW_W-1:0];
                default:         ; // unmapped address, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THRESHOLD:   prdata = DATA_W'(threshold_reg);
            REG_SKIP:        prdata = DATA_W'(skip_reg);
            REG_FRAME_WIDTH: prdata = DATA_W'(frame_width_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RST;
            skip_reg        <= SKIP_W'(1);
            frame_width_reg <= FW_W'(MAX_WIDTH);
        end
        else
        begin
            threshold_reg   <= threshold_next;
            skip_reg        <= skip_next;
            frame_width_reg <= frame_width_next;
        end
    end

    assign cfg.threshold   = threshold_reg;
    assign cfg.skip        = skip_reg;
    assign cfg.frame_width = frame_width_reg;

    // ---- front: position tracking and accumulation at pixel rate
    tfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .last_pixel (last_pixel),
        .queue_full (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    // ---- frame record queue decouples the pixel stream from the divider
    tfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // ---- back: means, speed map and result register
    tfc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_empty     (q_empty),
        .queue_data      (pop_data),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mean_x          (mean_x),
        .mean_y          (mean_y),
        .mean_brightness (mean_brightness),
        .speed_q8        (speed_q8),
        .found           (found)
    );

endmodule

>>> hdl/tfc_checker.sv
// Port-level checks on the result channel of the frame centroid core, with bind.
// Depends on tfc_pkg and thresholded_frame_centroid_core_defines.svh.
`timescale 1ns / 1ps
`include "thresholded_frame_centroid_core_defines.svh"

module tfc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [tfc_pkg::COL_W-1:0]   mean_x,
    input logic [tfc_pkg::ROW_W-1:0]   mean_y,
    input logic [7:0]                  mean_brightness,
    input logic [8:0]                  speed_q8,
    input logic                        found
);
    import tfc_pkg::*;

    // empty frame reports all-zero fields
    `TFC_ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid && !found, mean_x == '0 && mean_y == '0 && mean_brightness == '0 && speed_q8 == '0, "empty frame with nonzero fields")

    // speed stays inside its mapped range
    `TFC_ASSERT_IMPLY(a_speed_range, clk, rst_n, out_valid && found, speed_q8 >= 9'd77 && speed_q8 <= 9'd256, "speed out of range")

    // dark frames clamp to full speed
    `TFC_ASSERT_IMPLY(a_speed_low, clk, rst_n, out_valid && found && mean_brightness <= SPEED_LO, speed_q8 == 9'd256, "low brightness not at full speed")

    // a stalled result beat holds
    `TFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(mean_x) && $stable(mean_y) && $stable(mean_brightness) && $stable(speed_q8) && $stable(found), "stalled result changed")

endmodule

bind thresholded_frame_centroid_core tfc_checker u_tfc_checker (.*);
